/* rtl/wsfe_pkg.sv */
// ----------------------------------------------------------------------------
// wsfe_pkg
// Shared types, codes and helpers for the masked WebSocket frame encoder.
// ----------------------------------------------------------------------------
package wsfe_pkg;

    localparam int LEN_W   = 31;
    localparam int KEY_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int OP_W    = 4;

    localparam int QDEPTH  = 2;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCW     = $clog2(QDEPTH + 1);

    localparam int IDX_W   = 4;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    localparam logic [1:0] JOB_HDR   = 2'd0;
    localparam logic [1:0] JOB_DATA  = 2'd1;
    localparam logic [1:0] JOB_STRAY = 2'd2;

    localparam logic [1:0] FMT_SHORT = 2'd0;
    localparam logic [1:0] FMT_MID   = 2'd1;
    localparam logic [1:0] FMT_LONG  = 2'd2;

    localparam logic [BYTE_W-1:0] MASK_BIT  = 8'd128;
    localparam logic [LEN_W-1:0]  SHORT_MAX = 31'd125;
    localparam logic [LEN_W-1:0]  MID_MAX   = 31'd65535;
    localparam logic [6:0]        CODE_MID  = 7'd126;
    localparam logic [6:0]        CODE_LONG = 7'd127;

    localparam logic [IDX_W-1:0] KBASE_SHORT = 4'd2;
    localparam logic [IDX_W-1:0] KBASE_MID   = 4'd4;
    localparam logic [IDX_W-1:0] KBASE_LONG  = 4'd10;
    localparam logic [IDX_W-1:0] KEY_LAST    = 4'd3;
    localparam logic [IDX_W-1:0] EXT_BASE    = 4'd2;

    typedef struct packed {
        logic              command;
        logic [OP_W-1:0]   opcode;
        logic [LEN_W-1:0]  payload_length;
        logic [BYTE_W-1:0] payload_byte;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              frame_end;
        logic              run_end;
        logic              stray_byte;
    } t_out_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        fmt;
        logic [OP_W-1:0]   opcode;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] data;
        logic              frame_end;
    } t_job;

    function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] key,
                                                   input logic [1:0] pos);
        logic [BYTE_W-1:0] b;
        case (pos)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

endpackage

/* rtl/websocket_frame_encoder_core.sv */
// An accepted command's job passes through the job queue and then the output register.
// Throughput: one payload byte per cycle, set by the back half's output register, while
// the output is not stalled; a start command yields 6, 8 or 14 header beats, one per
// cycle, and the input stalls once the two-entry job queue fills behind it.
// Reset: synchronous, active low; clears frame state, queue, output valid and the key.
// ----------------------------------------------------------------------------
// websocket_frame_encoder_core
// Masked WebSocket frame encoder: header burst, then key-masked payload beats.
// ----------------------------------------------------------------------------
module websocket_frame_encoder_core
    import wsfe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_item,
    input  logic             i_cfg_we,
    input  logic [KEY_W-1:0] i_cfg_data
);

    logic [KEY_W-1:0] r_masking_key;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    t_job             job_in;
    t_job             job_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masking_key <= '0;
        end else if (i_cfg_we) begin
            r_masking_key <= i_cfg_data;
        end
    end

    wsfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (i_item),
        .i_key      (r_masking_key),
        .i_full     (full),
        .o_push     (push),
        .o_job      (job_in)
    );

    wsfe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_head  (job_head),
        .o_full  (full),
        .o_empty (empty)
    );

    wsfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (job_head),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_key       (r_masking_key),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_item      (o_item)
    );

endmodule

/* rtl/wsfe_front.sv */
// ----------------------------------------------------------------------------
// wsfe_front
// Accepts commands, tracks frame state and queues one job per command.
// ----------------------------------------------------------------------------
module wsfe_front
    import wsfe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_item,
    input  logic [KEY_W-1:0] i_key,
    input  logic             i_full,
    output logic             o_push,
    output t_job             o_job
);

    logic [LEN_W-1:0] r_bytes_left, n_bytes_left;
    logic [1:0]       r_key_pos, n_key_pos;
    logic             r_in_frame, n_in_frame;
    logic [LEN_W-1:0] dec_left;
    logic             accept;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;
    assign o_push     = accept;
    assign dec_left   = r_bytes_left - LEN_W'(1);

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_key_pos    = r_key_pos;
        n_in_frame   = r_in_frame;
        o_job        = '0;
        o_job.opcode = i_item.opcode;
        o_job.len    = i_item.payload_length;
        if (i_item.command == CMD_START) begin
            o_job.kind      = JOB_HDR;
            o_job.frame_end = (i_item.payload_length == '0);
            if (i_item.payload_length <= SHORT_MAX) begin
                o_job.fmt = FMT_SHORT;
            end else if (i_item.payload_length <= MID_MAX) begin
                o_job.fmt = FMT_MID;
            end else begin
                o_job.fmt = FMT_LONG;
            end
            n_bytes_left = i_item.payload_length;
            n_key_pos    = 2'd0;
            n_in_frame   = (i_item.payload_length != '0);
        end else if (!r_in_frame) begin
            o_job.kind = JOB_STRAY;
        end else begin
            o_job.kind      = JOB_DATA;
            o_job.data      = i_item.payload_byte ^ key_byte(i_key, r_key_pos);
            o_job.frame_end = (dec_left == '0);
            n_bytes_left    = dec_left;
            n_key_pos       = r_key_pos + 2'd1;
            n_in_frame      = (dec_left != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_key_pos    <= '0;
            r_in_frame   <= 1'b0;
        end else if (accept) begin
            r_bytes_left <= n_bytes_left;
            r_key_pos    <= n_key_pos;
            r_in_frame   <= n_in_frame;
        end
    end

    a_open_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> r_bytes_left != '0)
        else $error("open frame with no bytes left");

    a_idle_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame && $past(i_rst_n) && $past(accept) && $past(i_item.command) == CMD_BYTE
        |-> r_bytes_left == '0)
        else $error("frame closed with bytes left");

endmodule

/* rtl/wsfe_fifo.sv */
// ----------------------------------------------------------------------------
// wsfe_fifo
// Short job queue between the front and back halves.
// ----------------------------------------------------------------------------
module wsfe_fifo
    import wsfe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_full,
    output logic o_empty
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QCW-1:0] r_count;

    assign o_head  = r_mem[r_rptr];
    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QAW'(QDEPTH - 1)) ? '0 : r_wptr + QAW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QAW'(QDEPTH - 1)) ? '0 : r_rptr + QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

endmodule

/* rtl/wsfe_back.sv */
// ----------------------------------------------------------------------------
// wsfe_back
// Expands queued jobs into frame bytes through a registered output stage.
// ----------------------------------------------------------------------------
module wsfe_back
    import wsfe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_job             i_head,
    input  logic             i_empty,
    output logic             o_pop,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_item
);

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    t_out_item        r_out;
    t_out_item        n_out;
    logic [IDX_W-1:0] kbase;
    logic [IDX_W-1:0] ksel;
    logic [IDX_W-1:0] epos;
    logic [BYTE_W-1:0] hdr_byte;
    logic [BYTE_W-1:0] ext_byte;
    logic             last;
    logic             ld;
    logic             take;

    assign ld    = !r_valid || i_out_ready;
    assign take  = ld && !i_empty;
    assign o_pop = take && last;
    assign ksel  = r_idx - kbase;
    assign epos  = r_idx - EXT_BASE;

    always_comb begin
        case (i_head.fmt)
            FMT_SHORT: kbase = KBASE_SHORT;
            FMT_MID:   kbase = KBASE_MID;
            default:   kbase = KBASE_LONG;
        endcase
    end

    always_comb begin
        if (i_head.fmt == FMT_MID) begin
            ext_byte = (epos == '0) ? i_head.len[15:8] : i_head.len[7:0];
        end else begin
            case (epos)
                4'd4:    ext_byte = {1'b0, i_head.len[30:24]};
                4'd5:    ext_byte = i_head.len[23:16];
                4'd6:    ext_byte = i_head.len[15:8];
                4'd7:    ext_byte = i_head.len[7:0];
                default: ext_byte = '0;
            endcase
        end
    end

    always_comb begin
        if (r_idx == 4'd0) begin
            hdr_byte = MASK_BIT | {4'd0, i_head.opcode};
        end else if (r_idx == 4'd1) begin
            case (i_head.fmt)
                FMT_SHORT: hdr_byte = MASK_BIT | {1'b0, i_head.len[6:0]};
                FMT_MID:   hdr_byte = MASK_BIT | {1'b0, CODE_MID};
                default:   hdr_byte = MASK_BIT | {1'b0, CODE_LONG};
            endcase
        end else if (r_idx >= kbase) begin
            hdr_byte = key_byte(i_key, ksel[1:0]);
        end else begin
            hdr_byte = ext_byte;
        end
    end

    always_comb begin
        n_out = '0;
        last  = 1'b1;
        case (i_head.kind)
            JOB_HDR: begin
                last             = (r_idx == kbase + KEY_LAST);
                n_out.frame_byte = hdr_byte;
                n_out.frame_end  = last && i_head.frame_end;
            end
            JOB_DATA: begin
                n_out.frame_byte = i_head.data;
                n_out.frame_end  = i_head.frame_end;
            end
            default: begin
                n_out.stray_byte = 1'b1;
            end
        endcase
        n_out.run_end = last;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (ld) begin
                r_valid <= !i_empty;
            end
            if (take) begin
                r_idx <= last ? '0 : r_idx + IDX_W'(1);
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_item      = r_out;

    a_idx_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != '0 |-> !i_empty && i_head.kind == JOB_HDR)
        else $error("byte index live outside a header job");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= KBASE_LONG + KEY_LAST)
        else $error("header byte index out of range");

endmodule

/* tb/sv/wsfe_frame_checker.sv */
// ----------------------------------------------------------------------------
// wsfe_frame_checker
// Watches both channels and the key port of the frame encoder, predicts each
// output beat from the accepted commands, and compares the beats field by
// field in order.
// ----------------------------------------------------------------------------
module wsfe_frame_checker
    import wsfe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_in_item         i_in_item,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_out_item        i_out_item,
    input  logic             i_cfg_we,
    input  logic [KEY_W-1:0] i_cfg_data,
    output int               o_fails,
    output int               o_due,
    output int               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [BYTE_W-1:0] FIN_BIT    = 8'h80;
    localparam int                REPORT_MAX = 10;

    t_out_item         frame_bytes_due[$];
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  bytes_left;
    logic [1:0]        key_pos;
    logic              in_frame;

    function automatic logic [BYTE_W-1:0] key_lane(input logic [1:0] pos);
        logic [KEY_W-1:0] s;
        s = key >> (8 * (3 - int'(pos)));
        return s[BYTE_W-1:0];
    endfunction

    function automatic void push_beat(input logic [BYTE_W-1:0] b, input logic fend,
                                      input logic rend, input logic stray);
        t_out_item r;
        r.frame_byte = b;
        r.frame_end  = fend;
        r.run_end    = rend;
        r.stray_byte = stray;
        frame_bytes_due.push_back(r);
    endfunction

    function automatic void encode_beat(input t_in_item it);
        logic [BYTE_W-1:0] hdr[$];
        logic [LEN_W-1:0]  len;
        int                last;
        len = it.payload_length;
        if (it.command == CMD_BYTE) begin
            if (!in_frame) begin
                push_beat('0, 1'b0, 1'b1, 1'b1);
            end else begin
                bytes_left = bytes_left - 1'b1;
                push_beat(it.payload_byte ^ key_lane(key_pos), bytes_left == '0, 1'b1, 1'b0);
                key_pos = key_pos + 1'b1;
                if (bytes_left == '0) begin
                    in_frame = 1'b0;
                end
            end
        end else begin
            hdr.push_back(FIN_BIT | BYTE_W'(it.opcode));
            if (len <= SHORT_MAX) begin
                hdr.push_back(MASK_BIT | BYTE_W'(len));
            end else if (len <= MID_MAX) begin
                hdr.push_back(MASK_BIT | CODE_MID);
                hdr.push_back(len[15:8]);
                hdr.push_back(len[7:0]);
            end else begin
                hdr.push_back(MASK_BIT | CODE_LONG);
                repeat (4) hdr.push_back('0);
                hdr.push_back({1'b0, len[30:24]});
                hdr.push_back(len[23:16]);
                hdr.push_back(len[15:8]);
                hdr.push_back(len[7:0]);
            end
            for (int k = 0; k < 4; k++) begin
                hdr.push_back(key_lane(2'(k)));
            end
            last = hdr.size() - 1;
            foreach (hdr[k]) begin
                push_beat(hdr[k], (k == last) && (len == '0), k == last, 1'b0);
            end
            bytes_left = len;
            key_pos    = '0;
            in_frame   = (len != '0);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            frame_bytes_due.delete();
            key        = '0;
            bytes_left = '0;
            key_pos    = '0;
            in_frame   = 1'b0;
            o_fails    = 0;
            o_checked  = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (frame_bytes_due.size() == 0) begin
                    o_fails++;
                    if (o_fails <= REPORT_MAX) begin
                        $display("check: beat %0d unexpected, got byte %02h end %b run %b stray %b",
                                 o_checked, i_out_item.frame_byte, i_out_item.frame_end,
                                 i_out_item.run_end, i_out_item.stray_byte);
                    end
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (want.frame_byte !== i_out_item.frame_byte ||
                        want.frame_end  !== i_out_item.frame_end  ||
                        want.run_end    !== i_out_item.run_end    ||
                        want.stray_byte !== i_out_item.stray_byte) begin
                        o_fails++;
                        if (o_fails <= REPORT_MAX) begin
                            $display({"check: beat %0d expected byte %02h end %b run %b stray %b,",
                                      " got byte %02h end %b run %b stray %b"},
                                     o_checked, want.frame_byte, want.frame_end,
                                     want.run_end, want.stray_byte,
                                     i_out_item.frame_byte, i_out_item.frame_end,
                                     i_out_item.run_end, i_out_item.stray_byte);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                key = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                encode_beat(i_in_item);
            end
        end
        o_due = frame_bytes_due.size();
    end

endmodule

/* tb/sv/tb_websocket_frame_encoder_core.sv */
// ----------------------------------------------------------------------------
// tb_websocket_frame_encoder_core
// Drives start and payload commands into the frame encoder with random
// gaps and output stalls, changes the masking key once the encoder has drained, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_websocket_frame_encoder_core;
    timeunit 1ns;
    timeprecision 1ps;
    import wsfe_pkg::*;

    localparam int STUCK_LIMIT = 1000;
    localparam int PHASES      = 5;
    localparam int PHASE_BEATS = 100;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in_item         in_item   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_item        out_item;
    logic             cfg_we    = 1'b0;
    logic [KEY_W-1:0] cfg_data  = '0;

    int fails;
    int due;
    int checked;
    int sent;
    int starts;
    int key_writes;
    bit quiet;

    websocket_frame_encoder_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_item      (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_item      (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    wsfe_frame_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .o_fails     (fails),
        .o_due       (due),
        .o_checked   (checked)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic t_in_item mk_start(input logic [OP_W-1:0] op,
                                          input logic [LEN_W-1:0] len);
        t_in_item it;
        it.command        = CMD_START;
        it.opcode         = op;
        it.payload_length = len;
        it.payload_byte   = BYTE_W'($urandom);
        return it;
    endfunction

    function automatic t_in_item mk_byte(input logic [BYTE_W-1:0] b);
        t_in_item it;
        it.command        = CMD_BYTE;
        it.opcode         = OP_W'($urandom);
        it.payload_length = LEN_W'($urandom);
        it.payload_byte   = b;
        return it;
    endfunction

    task automatic put_beat(input t_in_item it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        sent++;
        if (it.command == CMD_START) begin
            starts++;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (due != 0);
        @(posedge clk);
    endtask

    task automatic set_key(input logic [KEY_W-1:0] k);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= k;
        @(posedge clk);
        cfg_we   <= 1'b0;
        key_writes++;
    endtask

    initial begin : out_side
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge clk);
            if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) begin
                stuck++;
            end else begin
                stuck = 0;
            end
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        logic [LEN_W-1:0]  len;
        logic [KEY_W-1:0]  key_val;
        t_in_item          junk;
        int                r;
        int                nbytes;
        int                target;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        put_beat(mk_byte(8'hFF));
        put_beat(mk_start(4'hF, '0));
        put_beat(mk_start(4'h1, 31'd1));
        put_beat(mk_byte(8'h00));
        put_beat(mk_byte(8'hAA));
        set_key(32'hA53C_0FF0);
        put_beat(mk_start(4'h8, '0));
        put_beat(mk_start(4'h2, 31'd5));
        put_beat(mk_byte(8'h00));
        put_beat(mk_byte(8'hFF));
        put_beat(mk_byte(8'h5A));
        put_beat(mk_byte(8'h3C));
        put_beat(mk_byte(8'h81));
        put_beat(mk_byte(8'h7E));
        put_beat(mk_start(4'h0, 31'd125));
        put_beat(mk_byte(8'h11));
        put_beat(mk_start(4'h9, 31'd126));
        put_beat(mk_byte(8'h22));
        put_beat(mk_start(4'hA, 31'd65535));
        put_beat(mk_start(4'h1, 31'd65536));
        put_beat(mk_start(4'h0, 31'h7FFF_FFFF));
        put_beat(mk_byte(8'hFF));
        put_beat(mk_start(4'h1, 31'd2));
        put_beat(mk_byte(8'hC3));
        put_beat(mk_byte(8'h3C));

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       key_val = 32'hFFFF_FFFF;
                2:       key_val = 32'h0000_0000;
                default: key_val = $urandom;
            endcase
            set_key(key_val);
            target = sent + PHASE_BEATS;
            while (sent < target) begin
                quiet = (ph == 2) || ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 9) == 0) begin
                    junk.command        = 1'($urandom);
                    junk.opcode         = OP_W'($urandom);
                    junk.payload_length = LEN_W'($urandom);
                    junk.payload_byte   = BYTE_W'($urandom);
                    put_beat(junk);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 60) begin
                        len = LEN_W'($urandom_range(0, 9));
                    end else if (r < 80) begin
                        len = LEN_W'($urandom_range(10, 40));
                    end else if (r < 86) begin
                        len = LEN_W'($urandom_range(41, 125));
                    end else if (r < 94) begin
                        len = LEN_W'($urandom_range(126, 65535));
                    end else begin
                        len = LEN_W'($urandom_range(65536, 32'h7FFF_FFFF));
                    end
                    if (len > 40) begin
                        nbytes = $urandom_range(0, 6);
                    end else if ($urandom_range(0, 9) == 0) begin
                        nbytes = $urandom_range(0, len);
                    end else begin
                        nbytes = len;
                    end
                    put_beat(mk_start(OP_W'($urandom), len));
                    repeat (nbytes) put_beat(mk_byte(BYTE_W'($urandom)));
                    if (nbytes == len && $urandom_range(0, 6) == 0) begin
                        repeat ($urandom_range(1, 2)) put_beat(mk_byte(BYTE_W'($urandom)));
                    end
                end
            end
            quiet = 1'b0;
        end

        drain();
        repeat (16) @(posedge clk);
        @(negedge clk);
        $display("tb: %0d input beats (%0d frame starts) under %0d key settings,",
                 sent, starts, key_writes + 1);
        $display("tb: %0d output beats compared, %0d mismatched", checked, fails);
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
